// File: sv/stable_priority_queue_unit_assert.svh
// assertion macros shared by the priority queue rtl
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spq_pkg.sv
// types and constants of the stable priority queue
package spq_pkg;

    localparam int SPQ_CAPACITY  = 16;
    localparam int SPQ_PRIO_BITS = 8;
    localparam int SPQ_DATA_BITS = 32;

    // operation codes of a command transaction
    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_EXTRACT = 2'd1,
        KIND_PEEK    = 2'd2
    } spq_kind_t;

    // status codes of a result transaction
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } spq_status_t;

    // command transaction
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] payload;
        logic [7:0]         prio;
    } spq_cmd_t;

    // result transaction
    typedef struct packed {
        logic signed [31:0] out_payload;
        logic [7:0]         out_prio;
        logic [1:0]         status;
        logic [4:0]         occupancy;
        logic               is_empty;
    } spq_res_t;

    // shift controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic ext;
    } spq_ctrl_t;

endpackage

// File: sv/spq_cell.sv
// one slot of the sorted shift chain
module spq_cell
    import spq_pkg::*;
#(
    parameter int DATA_BITS = SPQ_DATA_BITS,
    parameter int PRIO_BITS = SPQ_PRIO_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spq_ctrl_t            ctrl,
    input  logic [PRIO_BITS-1:0] new_prio,
    input  logic [DATA_BITS-1:0] new_data,
    input  logic                 prev_valid,
    input  logic [PRIO_BITS-1:0] prev_prio,
    input  logic [DATA_BITS-1:0] prev_data,
    input  logic                 prev_le,
    input  logic                 next_valid,
    input  logic [PRIO_BITS-1:0] next_prio,
    input  logic [DATA_BITS-1:0] next_data,
    output logic                 valid,
    output logic [PRIO_BITS-1:0] prio,
    output logic [DATA_BITS-1:0] data,
    output logic                 le
);

    logic                 valid_reg, valid_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [DATA_BITS-1:0] data_reg, data_next;

    // held entry goes ahead of the new one when its priority is not larger
    assign le = valid_reg && (prio_reg <= new_prio);

    // hold, take the new entry, or shift from a neighbor
    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        data_next  = data_reg;
        if (ctrl.ins)
        begin
            if (!le)
            begin
                if (prev_le)
                begin
                    valid_next = 1'b1;
                    prio_next  = new_prio;
                    data_next  = new_data;
                end
                else
                begin
                    valid_next = prev_valid;
                    prio_next  = prev_prio;
                    data_next  = prev_data;
                end
            end
        end
        else if (ctrl.ext)
        begin
            valid_next = next_valid;
            prio_next  = next_prio;
            data_next  = next_data;
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry contents
    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign data  = data_reg;

endmodule

// File: sv/stable_priority_queue_unit.sv
// top level of the stable priority queue: cell chain, counter and result register
//
// Usage: the command channel (cmd_valid, cmd_stall, cmd) carries an insert,
// an extract of the head or a peek at the head. The result channel
// (res_valid, res_stall, res) returns exactly one transaction per command:
// head data and priority for extract and peek, a status (ok, empty, full),
// the occupancy after the step and an empty flag.
// Entries are kept sorted in a chain of CAPACITY cells; a lower priority
// number leaves first and equal priorities leave in arrival order.
// The result is registered and valid in the cycle after the command is accepted.
// Throughput: one command per cycle while cmd_stall is low; every cell compares
// its own priority with the new one and shifts left or right in the same cycle.
// A result register decouples the channels: while a result waits under
// res_stall, cmd_stall is raised and no new command is taken.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending
// result; entries are ready for use in the first cycle after reset.
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY  = SPQ_CAPACITY,
    parameter int PRIO_BITS = SPQ_PRIO_BITS,
    parameter int DATA_BITS = SPQ_DATA_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  spq_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_stall,
    output spq_res_t res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                 accept;
    spq_ctrl_t            ctrl;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 res_valid_reg;
    spq_res_t             res_reg, res_next;

    logic [CAPACITY-1:0]  valid_vec;
    logic [CAPACITY-1:0]  le_vec;
    logic [PRIO_BITS-1:0] prio_arr [CAPACITY];
    logic [DATA_BITS-1:0] data_arr [CAPACITY];

    logic [PRIO_BITS+7:0] new_prio_ext;
    logic [DATA_BITS+31:0] new_data_ext;
    logic [PRIO_BITS-1:0] new_prio;
    logic [DATA_BITS-1:0] new_data;
    logic [PRIO_BITS+7:0] head_prio_ext;
    logic [DATA_BITS+31:0] head_data_ext;
    logic [CNT_W+4:0]     occ_ext;
    logic                 is_full;
    logic                 no_entries;

    // handshake
    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;

    // fit input fields to the stored widths
    assign new_prio_ext = {{PRIO_BITS{1'b0}}, cmd.prio};
    assign new_data_ext = {{DATA_BITS{1'b0}}, cmd.payload};
    assign new_prio     = new_prio_ext[PRIO_BITS-1:0];
    assign new_data     = new_data_ext[DATA_BITS-1:0];

    // head entry widened to the result fields
    assign head_prio_ext = {8'd0, prio_arr[0]};
    assign head_data_ext = {32'd0, data_arr[0]};

    assign is_full    = valid_vec[CAPACITY-1];
    assign no_entries = !valid_vec[0];

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                 p_valid, p_le, n_valid;
        logic [PRIO_BITS-1:0] p_prio, n_prio;
        logic [DATA_BITS-1:0] p_data, n_data;

        if (i == 0)
        begin : g_first
            assign p_valid = 1'b0;
            assign p_prio  = '0;
            assign p_data  = '0;
            assign p_le    = 1'b1;
        end
        else
        begin : g_inner_left
            assign p_valid = valid_vec[i-1];
            assign p_prio  = prio_arr[i-1];
            assign p_data  = data_arr[i-1];
            assign p_le    = le_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign n_valid = 1'b0;
            assign n_prio  = '0;
            assign n_data  = '0;
        end
        else
        begin : g_inner_right
            assign n_valid = valid_vec[i+1];
            assign n_prio  = prio_arr[i+1];
            assign n_data  = data_arr[i+1];
        end

        spq_cell #(
            .DATA_BITS (DATA_BITS),
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_prio   (new_prio),
            .new_data   (new_data),
            .prev_valid (p_valid),
            .prev_prio  (p_prio),
            .prev_data  (p_data),
            .prev_le    (p_le),
            .next_valid (n_valid),
            .next_prio  (n_prio),
            .next_data  (n_data),
            .valid      (valid_vec[i]),
            .prio       (prio_arr[i]),
            .data       (data_arr[i]),
            .le         (le_vec[i])
        );
    end

    // decode the command and build its result
    always_comb
    begin
        ctrl                 = '0;
        count_next           = count_reg;
        res_next.out_payload = '0;
        res_next.out_prio    = '0;
        res_next.status      = STATUS_OK;
        case (cmd.kind)
            KIND_INSERT:
            begin
                if (is_full)
                begin
                    res_next.status = STATUS_FULL;
                end
                else
                begin
                    ctrl.ins   = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_EXTRACT:
            begin
                if (no_entries)
                begin
                    res_next.status = STATUS_EMPTY;
                end
                else
                begin
                    ctrl.ext             = accept;
                    count_next           = count_reg - CNT_W'(1);
                    res_next.out_payload = head_data_ext[31:0];
                    res_next.out_prio    = head_prio_ext[7:0];
                end
            end
            KIND_PEEK:
            begin
                if (no_entries)
                begin
                    res_next.status = STATUS_EMPTY;
                end
                else
                begin
                    res_next.out_payload = head_data_ext[31:0];
                    res_next.out_prio    = head_prio_ext[7:0];
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
        occ_ext            = {5'd0, count_next};
        res_next.occupancy = occ_ext[4:0];
        res_next.is_empty  = (count_next == '0);
    end

    // entry counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // checks on the chain and the counter
    `include "stable_priority_queue_unit_assert.svh"

    `SPQ_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(valid_vec) == count_reg, "count differs from occupied cells")
    `SPQ_ASSERT_NOW(a_head_sorted, valid_vec[1], prio_arr[0] <= prio_arr[1], "head cells out of order")
    `SPQ_ASSERT_NEXT(a_extract_shrinks, accept && cmd.kind == KIND_EXTRACT && count_reg != '0, count_reg == $past(count_reg) - CNT_W'(1), "extract did not remove an entry")
    `SPQ_ASSERT_NEXT(a_full_insert_holds, accept && cmd.kind == KIND_INSERT && is_full, $stable(valid_vec) && res.status == STATUS_FULL, "insert into full queue changed state")

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench of the stable priority queue unit
module testbench;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PRINT_CAP      = 40;

    // one entry held by the predicted queue
    typedef struct packed {
        logic signed [31:0] payload;
        logic [7:0]         prio;
    } held_entry_t;

    // traffic shape of a random phase
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } load_mode_t;

    // sorted queue prediction and result comparison
    class pq_scoreboard;
        held_entry_t held[$];
        spq_res_t    pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            if (errors < PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // apply one accepted command to the predicted queue
        function void note_command(input spq_cmd_t c);
            spq_res_t    r;
            held_entry_t e;
            int          pos;
            r = '0;
            r.status = STATUS_OK;
            case (c.kind)
                KIND_INSERT:
                begin
                    if (held.size() >= SPQ_CAPACITY)
                        r.status = STATUS_FULL;
                    else
                    begin
                        // new entry goes after every entry of equal or better priority
                        pos = 0;
                        while (pos < held.size() && held[pos].prio <= c.prio)
                            pos++;
                        e.payload = c.payload;
                        e.prio    = c.prio;
                        held.insert(pos, e);
                    end
                end
                KIND_EXTRACT, KIND_PEEK:
                begin
                    if (held.size() == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        r.out_payload = held[0].payload;
                        r.out_prio    = held[0].prio;
                        if (c.kind == KIND_EXTRACT)
                            void'(held.pop_front());
                    end
                end
                default:
                    ;
            endcase
            r.occupancy = 5'(held.size());
            r.is_empty  = (held.size() == 0);
            pending.push_back(r);
        endfunction

        // compare a result transaction against the oldest prediction
        task check_result(input spq_res_t got);
            spq_res_t wanted;
            if (pending.size() == 0)
            begin
                report("result transaction with no command outstanding");
                return;
            end
            wanted = pending.pop_front();
            if (got.out_payload !== wanted.out_payload)
                report($sformatf("out_payload got %0d want %0d",
                                 got.out_payload, wanted.out_payload));
            if (got.out_prio !== wanted.out_prio)
                report($sformatf("out_prio got %0d want %0d",
                                 got.out_prio, wanted.out_prio));
            if (got.status !== wanted.status)
                report($sformatf("status got %0d want %0d", got.status, wanted.status));
            if (got.occupancy !== wanted.occupancy)
                report($sformatf("occupancy got %0d want %0d",
                                 got.occupancy, wanted.occupancy));
            if (got.is_empty !== wanted.is_empty)
                report($sformatf("is_empty got %0b want %0b",
                                 got.is_empty, wanted.is_empty));
        endtask
    endclass

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    spq_cmd_t cmd;
    logic     res_valid;
    logic     res_stall;
    spq_res_t res;

    pq_scoreboard sb;
    bit           quiet;
    int           idle_cycles;
    int           stall_left;
    int           sent;

    stable_priority_queue_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // result channel back-pressure
    initial
    begin
        res_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall  <= 1'b0;
                stall_left = quiet ? 0 : idle_len();
            end
        end
    end

    // monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(cmd);
            if (res_valid && !res_stall)
                sb.check_result(res);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // drive one command transaction and wait until it is taken
    task automatic issue_command(input spq_kind_t k, input logic signed [31:0] pay,
                                 input logic [7:0] pr);
        spq_cmd_t c;
        int       gap;
        c.kind    = k;
        c.payload = pay;
        c.prio    = pr;
        gap = quiet ? 0 : idle_len();
        repeat (gap)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    // random priority: many near ties, some full range, some extremes
    function automatic logic [7:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 8'($urandom_range(0, 3));
        if (r < 85)
            return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
    endfunction

    // random payload with occasional extremes
    function automatic logic signed [31:0] pick_payload();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'sh7fffffff;
        if (r == 1)
            return 32'sh80000000;
        return $urandom;
    endfunction

    // one random command shaped by the phase mode
    task automatic random_command(input load_mode_t mode);
        int r;
        int ins_lim;
        int ext_lim;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                ins_lim = 70;
                ext_lim = 88;
            end
            MODE_DRAIN:
            begin
                ins_lim = 20;
                ext_lim = 85;
            end
            default:
            begin
                ins_lim = 45;
                ext_lim = 85;
            end
        endcase
        if (r < ins_lim)
            issue_command(KIND_INSERT, pick_payload(), pick_prio());
        else if (r < ext_lim)
            issue_command(KIND_EXTRACT, pick_payload(), pick_prio());
        else
            issue_command(KIND_PEEK, pick_payload(), pick_prio());
    endtask

    logic [7:0]         fill_prio [16] = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd0,
                                           8'd255, 8'd1, 8'd254, 8'd128, 8'd0, 8'd7,
                                           8'd7, 8'd200, 8'd255, 8'd3};
    logic signed [31:0] fill_data [5] = '{32'sh7fffffff, 32'sh80000000, 32'sd0,
                                          -32'sd1, 32'sd1};

    // main sequence
    initial
    begin
        int         phase_len;
        load_mode_t mode;
        sb          = new();
        quiet       = 1'b0;
        idle_cycles = 0;
        sent        = 0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty queue, fill with ties and extremes, full, head access
        issue_command(KIND_PEEK, 32'sd0, 8'd0);
        issue_command(KIND_EXTRACT, 32'sd0, 8'd0);
        for (int i = 0; i < 16; i++)
            issue_command(KIND_INSERT, (i < 5) ? fill_data[i] : $urandom, fill_prio[i]);
        issue_command(KIND_INSERT, 32'sd123, 8'd0);
        issue_command(KIND_PEEK, 32'sd0, 8'd0);
        repeat (3)
            issue_command(KIND_EXTRACT, 32'sd0, 8'd0);

        // random phases swinging the queue between empty and full
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(10, 60);
            mode      = load_mode_t'($urandom_range(0, 2));
            quiet     = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
                random_command(mode);
        end
        quiet = 1'b0;
        @(negedge clk);
        cmd_valid <= 1'b0;

        // let every outstanding result come back
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
